### design/tmac_pkg.sv
// types, constants and divide step shared by the running mean accumulator
`default_nettype none

package tmac_pkg;

    localparam int NUM_ELEMENTS_DEF = 1024;
    localparam int DIV_W = 25;
    localparam logic [16:0] INC_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REG_KEEP_EVERY  = 2'd0,
        REG_BURN_IN     = 2'd1,
        REG_SPARSE_MODE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [23:0]        iteration;
        logic [9:0]         element_index;
        logic signed [31:0] sample_value;
    } t_in;

    typedef struct packed {
        logic               kept;
        logic [9:0]         result_index;
        logic [23:0]        sample_slot;
        logic signed [31:0] running_mean;
        logic [63:0]        square_mean;
        logic [16:0]        inclusion_rate;
    } t_out;

    typedef struct packed {
        logic [31:0] mean;
        logic [63:0] sq;
        logic [16:0] inc;
    } t_entry;

    typedef struct packed {
        logic               v;
        logic               kept;
        logic               inr;
        logic [9:0]         idx;
        logic [23:0]        slot;
        logic [DIV_W-1:0]   d;
        logic signed [31:0] x;
        logic [63:0]        sq;
    } t_req;

    typedef struct packed {
        logic               v;
        logic               inr;
        logic               ge;
        logic [9:0]         idx;
        logic signed [31:0] x;
        logic [63:0]        sq;
    } t_fside;

    typedef struct packed {
        logic        v;
        logic        kept;
        logic        inr;
        logic [9:0]  idx;
        logic [23:0] slot;
        logic [31:0] mean;
        logic [63:0] sq;
        logic [16:0] inc;
        logic        s_mean;
        logic        s_sq;
        logic        s_inc;
    } t_uside;

    typedef struct packed {
        logic       we;
        logic [9:0] idx;
        t_entry     data;
    } t_wr;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [3:0]       q;
    } t_dstep;

    // four restoring divide steps, one quotient bit each
    function automatic t_dstep div_step4(input logic [DIV_W-1:0] rem,
                                         input logic [3:0] bits,
                                         input logic [DIV_W-1:0] dv);
        logic [DIV_W:0] t;
        t_dstep r;
        r.rem = rem;
        r.q = '0;
        for (int k = 3; k >= 0; k--) begin
            t = {r.rem, bits[k]};
            if (t >= {1'b0, dv}) begin
                t = t - {1'b0, dv};
                r.q[k] = 1'b1;
            end
            r.rem = t[DIV_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/tmac_divpipe.sv
// pipelined restoring divider, four quotient bits per stage until the quotient is complete, then hold stages
`default_nettype none

module tmac_divpipe #(
    parameter int W = 24,
    parameter int DEPTH = 6
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [W-1:0]               i_dividend,
    input  logic [tmac_pkg::DIV_W-1:0] i_divisor,
    output logic [W-1:0]               o_quot,
    output logic [tmac_pkg::DIV_W-1:0] o_rem
);
    import tmac_pkg::*;

    localparam int STEPS = W / 4;

    logic [W-1:0]     r_word [DEPTH];
    logic [DIV_W-1:0] r_rem  [DEPTH];
    logic [DIV_W-1:0] r_dv   [DEPTH];
    logic [W-1:0]     w_word_in [DEPTH];
    logic [DIV_W-1:0] w_rem_in  [DEPTH];
    logic [DIV_W-1:0] w_dv_in   [DEPTH];

    for (genvar s = 0; s < DEPTH; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_word_in[s] = i_dividend;
            assign w_rem_in[s]  = '0;
            assign w_dv_in[s]   = i_divisor;
        end else begin : g_next
            assign w_word_in[s] = r_word[s-1];
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_dv_in[s]   = r_dv[s-1];
        end
        if (s < STEPS) begin : g_step
            t_dstep w_ds;
            assign w_ds = div_step4(w_rem_in[s], w_word_in[s][W-1 -: 4], w_dv_in[s]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_word[s] <= {w_word_in[s][W-5:0], w_ds.q};
                    r_rem[s]  <= w_ds.rem;
                    r_dv[s]   <= w_dv_in[s];
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_word[s] <= w_word_in[s];
                    r_rem[s]  <= w_rem_in[s];
                    r_dv[s]   <= w_dv_in[s];
                end
            end
        end
    end

    assign o_quot = r_word[DEPTH-1];
    assign o_rem  = r_rem[DEPTH-1];

endmodule

`default_nettype wire

### design/tmac_front.sv
// input stage: thinning check, slot divide and sample square
`default_nettype none

module tmac_front #(
    parameter int NUM_ELEMENTS = tmac_pkg::NUM_ELEMENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tmac_pkg::t_in  i_data,
    input  logic [15:0]    i_keep_every,
    input  logic [23:0]    i_burn_in,
    output tmac_pkg::t_req o_req
);
    import tmac_pkg::*;

    localparam int DEPTH = 6;

    t_fside           r_side [DEPTH];
    t_fside           n_side0;
    t_fside           w_side1;
    t_req             r_req;
    t_req             n_req;
    logic [DIV_W-1:0] w_dv;
    logic [23:0]      w_qi;
    logic [23:0]      w_qb;
    logic [DIV_W-1:0] w_ri;
    logic [31:0]      w_ax;
    logic [63:0]      w_sq;
    logic             w_kept;

    assign w_dv = DIV_W'(i_keep_every);

    tmac_divpipe #(.W(24), .DEPTH(DEPTH)) u_div_iter (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (i_data.iteration),
        .i_divisor  (w_dv),
        .o_quot     (w_qi),
        .o_rem      (w_ri)
    );

    tmac_divpipe #(.W(24), .DEPTH(DEPTH)) u_div_burn (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (i_burn_in),
        .i_divisor  (w_dv),
        .o_quot     (w_qb),
        .o_rem      ()
    );

    always_comb begin
        n_side0     = '0;
        n_side0.v   = i_valid;
        n_side0.inr = 32'(i_data.element_index) < NUM_ELEMENTS;
        n_side0.ge  = i_data.iteration >= i_burn_in;
        n_side0.idx = i_data.element_index;
        n_side0.x   = i_data.sample_value;
    end

    assign w_ax = r_side[0].x[31] ? (32'd0 - $unsigned(r_side[0].x)) : $unsigned(r_side[0].x);
    assign w_sq = w_ax * w_ax;

    always_comb begin
        w_side1    = r_side[0];
        w_side1.sq = w_sq;
    end

    always_comb begin
        w_kept      = r_side[DEPTH-1].inr && r_side[DEPTH-1].ge && (w_ri == '0);
        n_req       = '0;
        n_req.v     = r_side[DEPTH-1].v;
        n_req.kept  = w_kept;
        n_req.inr   = r_side[DEPTH-1].inr;
        n_req.idx   = r_side[DEPTH-1].idx;
        n_req.slot  = w_kept ? (w_qi - w_qb) : 24'd0;
        n_req.d     = {1'b0, n_req.slot} + 25'd1;
        n_req.x     = r_side[DEPTH-1].x;
        n_req.sq    = r_side[DEPTH-1].sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_side[k] <= '0;
            end
            r_req <= '0;
        end else if (i_en) begin
            r_side[0] <= n_side0;
            r_side[1] <= w_side1;
            for (int k = 2; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

`default_nettype wire

### design/tmac_store.sv
// per-element mean memory with clearing sweep after reset
`default_nettype none

module tmac_store #(
    parameter int NUM_ELEMENTS = tmac_pkg::NUM_ELEMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en_front,
    input  logic [9:0]       i_r0_idx,
    input  logic [9:0]       i_r1_idx,
    input  tmac_pkg::t_wr    i_wr,
    output tmac_pkg::t_entry o_rdata,
    output logic             o_clearing
);
    import tmac_pkg::*;

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

    t_entry        r_mem [NUM_ELEMENTS];
    t_entry        r_rdata;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    // read data always belongs to the request sitting in the read stage
    assign w_rd_addr = i_en_front ? AW'(i_r0_idx) : AW'(i_r1_idx);
    assign w_wr_addr = AW'(i_wr.idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == AW'(NUM_ELEMENTS - 1)) begin
                r_clr <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.we) begin
            r_mem[w_wr_addr] <= i_wr.data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr;

endmodule

`default_nettype wire

### design/tmac_update.sv
// read-modify-write pipeline: differences, mean divides, write back
`default_nettype none

module tmac_update (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_en_front,
    input  tmac_pkg::t_req   i_req,
    input  tmac_pkg::t_entry i_rdata,
    input  logic             i_sparse,
    output logic             o_hazard,
    output logic [9:0]       o_r1_idx,
    output logic             o_fin_v,
    output tmac_pkg::t_out   o_fin,
    output tmac_pkg::t_wr    o_wr
);
    import tmac_pkg::*;

    localparam int DEPTH = 16;
    localparam int MW = 36;
    localparam int SW = 64;
    localparam int IW = 20;

    t_req             r_r1;
    t_uside           r_side [DEPTH+1];
    t_uside           n_side0;
    t_uside           w_last;
    logic [MW-1:0]    r_mag_m;
    logic [SW-1:0]    r_mag_s;
    logic [IW-1:0]    r_mag_i;
    logic [DIV_W-1:0] r_d;
    logic [32:0]      w_diff;
    logic [32:0]      w_abs_m;
    logic [63:0]      w_abs_s;
    logic [16:0]      w_tgt;
    logic [16:0]      w_abs_i;
    logic [MW-1:0]    w_qm;
    logic [SW-1:0]    w_qs;
    logic [IW-1:0]    w_qi;
    logic             w_hit;
    t_entry           w_new;

    assign w_diff  = {r_r1.x[31], r_r1.x} - {i_rdata.mean[31], i_rdata.mean};
    assign w_abs_m = w_diff[32] ? (33'd0 - w_diff) : w_diff;
    assign w_abs_s = (r_r1.sq < i_rdata.sq) ? (i_rdata.sq - r_r1.sq) : (r_r1.sq - i_rdata.sq);
    assign w_tgt   = (r_r1.x != 0) ? INC_ONE : 17'd0;
    assign w_abs_i = (w_tgt < i_rdata.inc) ? (i_rdata.inc - w_tgt) : (w_tgt - i_rdata.inc);

    always_comb begin
        n_side0        = '0;
        n_side0.v      = r_r1.v;
        n_side0.kept   = r_r1.kept;
        n_side0.inr    = r_r1.inr;
        n_side0.idx    = r_r1.idx;
        n_side0.slot   = r_r1.slot;
        n_side0.mean   = i_rdata.mean;
        n_side0.sq     = i_rdata.sq;
        n_side0.inc    = i_rdata.inc;
        n_side0.s_mean = w_diff[32];
        n_side0.s_sq   = r_r1.sq < i_rdata.sq;
        n_side0.s_inc  = w_tgt < i_rdata.inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1 <= '0;
            for (int k = 0; k <= DEPTH; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_r1      <= i_en_front ? i_req : '0;
            r_side[0] <= n_side0;
            for (int k = 1; k <= DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_m <= MW'(w_abs_m);
            r_mag_s <= w_abs_s;
            r_mag_i <= IW'(w_abs_i);
            r_d     <= r_r1.d;
        end
    end

    tmac_divpipe #(.W(MW), .DEPTH(DEPTH)) u_div_mean (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_mag_m),
        .i_divisor  (r_d),
        .o_quot     (w_qm),
        .o_rem      ()
    );

    tmac_divpipe #(.W(SW), .DEPTH(DEPTH)) u_div_sq (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_mag_s),
        .i_divisor  (r_d),
        .o_quot     (w_qs),
        .o_rem      ()
    );

    tmac_divpipe #(.W(IW), .DEPTH(DEPTH)) u_div_inc (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_mag_i),
        .i_divisor  (r_d),
        .o_quot     (w_qi),
        .o_rem      ()
    );

    // same element still in flight between read and write back
    always_comb begin
        w_hit = r_r1.v && r_r1.kept && (r_r1.idx == i_req.idx);
        for (int k = 0; k <= DEPTH; k++) begin
            w_hit = w_hit || (r_side[k].v && r_side[k].kept && (r_side[k].idx == i_req.idx));
        end
        o_hazard = i_req.v && i_req.inr && w_hit;
    end

    assign w_last = r_side[DEPTH];

    always_comb begin
        w_new.mean = w_last.s_mean ? (w_last.mean - w_qm[31:0]) : (w_last.mean + w_qm[31:0]);
        w_new.sq   = w_last.s_sq ? (w_last.sq - w_qs) : (w_last.sq + w_qs);
        if (i_sparse) begin
            w_new.inc = w_last.s_inc ? (w_last.inc - w_qi[16:0]) : (w_last.inc + w_qi[16:0]);
        end else begin
            w_new.inc = w_last.inc;
        end

        o_fin              = '0;
        o_fin.result_index = w_last.idx;
        if (w_last.inr) begin
            if (w_last.kept) begin
                o_fin.kept           = 1'b1;
                o_fin.sample_slot    = w_last.slot;
                o_fin.running_mean   = w_new.mean;
                o_fin.square_mean    = w_new.sq;
                o_fin.inclusion_rate = w_new.inc;
            end else begin
                o_fin.running_mean   = w_last.mean;
                o_fin.square_mean    = w_last.sq;
                o_fin.inclusion_rate = w_last.inc;
            end
        end

        o_wr.we   = w_last.v && w_last.kept && i_en;
        o_wr.idx  = w_last.idx;
        o_wr.data = w_new;
    end

    assign o_fin_v  = w_last.v;
    assign o_r1_idx = r_r1.idx;

endmodule

`default_nettype wire

### design/thinned_running_mean_accumulator.sv
// top level of the thinned running mean accumulator
//
// input channel i_valid/o_stall carries one vector element per request:
// iteration, element index and Q8.24 value. output channel o_valid/i_stall
// returns one result per request in the same order.
// configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data).
// the user must write it only while no request is in flight; the block
// does not enforce this. the result path runs through the slot divide
// (6 stages) and the three mean divides (16 stages each, with at most four
// quotient bits per stage).
// throughput: one request per cycle for different elements, unless the
// clearing sweep or a held output stalls the input. a request for an
// element whose update is still in flight waits until it is written back,
// since each update is a read-modify-write of the per-element memory.
// reset: config returns to defaults and a clearing sweep zeroes the
// memory, one entry a cycle, with o_stall high until the sweep ends.
// when the receiver stalls, the result is held, one more result goes into
// a skid register and then the whole pipeline and o_stall hold.
`default_nettype none

module thinned_running_mean_accumulator #(
    parameter int NUM_ELEMENTS = tmac_pkg::NUM_ELEMENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tmac_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output tmac_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [23:0]    i_cfg_data
);
    import tmac_pkg::*;

    logic [15:0] r_keep_every;
    logic [23:0] r_burn_in;
    logic        r_sparse;
    t_out        r_out;
    t_out        r_skid;
    logic        r_out_v;
    logic        r_skid_v;

    logic        w_en;
    logic        w_en_front;
    logic        w_hazard;
    logic        w_clearing;
    logic        w_fin_v;
    logic        w_take;
    logic [15:0] w_ke;
    logic [9:0]  w_r1_idx;
    t_out        w_fin;
    t_req        w_req;
    t_entry      w_rdata;
    t_wr         w_wr;

    assign w_ke       = (r_keep_every == '0) ? 16'd1 : r_keep_every;
    assign w_en       = !r_skid_v;
    assign w_en_front = w_en && !w_clearing && !w_hazard;
    assign w_take     = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_every <= 16'd1;
            r_burn_in    <= '0;
            r_sparse     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_KEEP_EVERY: begin
                    r_keep_every <= i_cfg_data[15:0];
                end
                REG_BURN_IN: begin
                    r_burn_in <= i_cfg_data;
                end
                REG_SPARSE_MODE: begin
                    r_sparse <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    tmac_front #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en_front),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .i_keep_every (w_ke),
        .i_burn_in    (r_burn_in),
        .o_req        (w_req)
    );

    tmac_store #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en_front (w_en_front),
        .i_r0_idx   (w_req.idx),
        .i_r1_idx   (w_r1_idx),
        .i_wr       (w_wr),
        .o_rdata    (w_rdata),
        .o_clearing (w_clearing)
    );

    tmac_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_en_front (w_en_front),
        .i_req      (w_req),
        .i_rdata    (w_rdata),
        .i_sparse   (r_sparse),
        .o_hazard   (w_hazard),
        .o_r1_idx   (w_r1_idx),
        .o_fin_v    (w_fin_v),
        .o_fin      (w_fin),
        .o_wr       (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_fin_v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_fin_v) begin
            if (!r_out_v || w_take) begin
                r_out <= w_fin;
            end else begin
                r_skid <= w_fin;
            end
        end
    end

    assign o_stall = !w_en_front;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

### design/tmac_chk.sv
// port checker for the running mean accumulator, bound to the top level
`default_nettype none

module tmac_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input tmac_pkg::t_out o_data
);
    import tmac_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped or changed under stall");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.kept |-> o_data.sample_slot == 24'd0)
        else $error("slot reported for a request that was not kept");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.inclusion_rate <= INC_ONE)
        else $error("inclusion rate above one");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("not idle and stalled after reset");

endmodule

bind thinned_running_mean_accumulator tmac_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

### bench/tmac_checker.sv
// checker for the running mean accumulator: predicts and compares each result
module tmac_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_stall,
    input  tmac_pkg::t_in   i_data,
    input  logic            o_valid,
    input  logic            i_stall,
    input  tmac_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [23:0]     i_cfg_data,
    output int              o_errors,
    output int              o_pending,
    output int              o_results,
    output int              o_kept
);
    timeunit 1ns;
    timeprecision 1ps;
    import tmac_pkg::*;

    localparam int NUM_EL = 1024;

    logic [15:0] keep_every_q;
    logic [23:0] burn_in_q;
    logic        sparse_q;
    logic [31:0] mean_mem [NUM_EL];
    logic [63:0] sq_mem [NUM_EL];
    logic [16:0] inc_mem [NUM_EL];
    t_out        expected_results [$];

    function automatic logic [63:0] approach(input logic [63:0] m, input logic [63:0] x,
                                             input logic [63:0] d);
        if (x >= m)
            return m + (x - m) / d;
        return m - (m - x) / d;
    endfunction

    function automatic t_out update_means(input t_in req);
        t_out r;
        logic [23:0] ke;
        logic [63:0] d;
        logic [63:0] ax;
        longint signed m;
        longint signed diff;
        longint signed xv;
        r = '0;
        r.result_index = req.element_index;
        ke = (keep_every_q == 0) ? 24'd1 : {8'd0, keep_every_q};
        xv = req.sample_value;
        if ((req.iteration % ke) == 0 && req.iteration >= burn_in_q) begin
            r.kept = 1'b1;
            r.sample_slot = req.iteration / ke - burn_in_q / ke;
            d = {40'd0, r.sample_slot} + 64'd1;
            m = $signed(mean_mem[req.element_index]);
            diff = xv - m;
            mean_mem[req.element_index] = 32'(m + diff / longint'(d));
            ax = (xv < 0) ? 64'(-xv) : 64'(xv);
            sq_mem[req.element_index] = approach(sq_mem[req.element_index], ax * ax, d);
            if (sparse_q)
                inc_mem[req.element_index] = 17'(approach({47'd0, inc_mem[req.element_index]},
                    (xv != 0) ? 64'd65536 : 64'd0, d));
        end
        r.running_mean = mean_mem[req.element_index];
        r.square_mean = sq_mem[req.element_index];
        r.inclusion_rate = inc_mem[req.element_index];
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            keep_every_q <= 16'd1;
            burn_in_q <= '0;
            sparse_q <= 1'b0;
            for (int i = 0; i < NUM_EL; i++) begin
                mean_mem[i] = '0;
                sq_mem[i] = '0;
                inc_mem[i] = '0;
            end
            expected_results.delete();
            o_errors <= 0;
            o_results <= 0;
            o_kept <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_KEEP_EVERY:  keep_every_q <= i_cfg_data[15:0];
                    REG_BURN_IN:     burn_in_q <= i_cfg_data;
                    REG_SPARSE_MODE: sparse_q <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                expected_results.insert(expected_results.size(), update_means(i_data));
            if (o_valid && !i_stall) begin
                o_results <= o_results + 1;
                if (o_data.kept)
                    o_kept <= o_kept + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== o_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, o_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### bench/tb_top.sv
// top of the running mean accumulator testbench: stimulus, configuration and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tmac_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    int          errors;
    int          pending;
    int          results;
    int          kept_count;
    int          stall_mode;
    int          sent;

    thinned_running_mean_accumulator i_dut (.*);

    tmac_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_kept(kept_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic write_reg(input t_reg_idx idx, input logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // drive one request and hold it until taken; gap decides idle cycles after
    task automatic send_request(input logic [23:0] iter, input logic [9:0] idx,
                                input logic [31:0] val, input int gap);
        i_valid <= 1'b1;
        i_data <= '{iteration: iter, element_index: idx, sample_value: val};
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_phase(input int n, input logic [15:0] ke, input logic [23:0] bi,
                                input bit sparse);
        int burst;
        int k;
        logic [23:0] it;
        logic [31:0] v;
        logic [9:0] el;
        int base;
        write_reg(REG_KEEP_EVERY, {8'd0, ke});
        write_reg(REG_BURN_IN, bi);
        write_reg(REG_SPARSE_MODE, {23'd0, sparse});
        stall_mode = $urandom_range(0, 3);
        base = (ke == 0) ? 1 : int'(ke);
        burst = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: it = 24'($urandom);
                1: it = 24'(int'(bi) + $urandom_range(0, 3));
                default: it = 24'((int'(bi) / base + $urandom_range(0, 40)) * base);
            endcase
            case ($urandom_range(0, 7))
                0: v = 32'd0;
                1: v = 32'h8000_0000;
                2: v = 32'h7fff_ffff;
                3: v = $urandom_range(0, 1) ? 32'(-$urandom_range(1, 255)) : 32'h0;
                default: v = $urandom;
            endcase
            el = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                send_request(it, el, v, $urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
            end else begin
                send_request(it, el, v, 0);
            end
        end
        i_valid <= 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_KEEP_EVERY;
        i_cfg_data = '0;
        stall_mode = 0;
        sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);

        // directed: default config, extremes of fields
        send_request(24'd0, 10'd0, 32'h7fff_ffff, 0);
        send_request(24'd1, 10'd0, 32'h8000_0000, 0);
        send_request(24'hffffff, 10'd1023, 32'h8000_0000, 1);
        send_request(24'd2, 10'd1023, 32'h0, 0);
        send_request(24'd3, 10'd5, 32'hffff_ffff, 0);
        i_valid <= 1'b0;
        drain();
        write_reg(REG_SPARSE_MODE, 24'd1);
        write_reg(REG_KEEP_EVERY, 24'd0);
        send_request(24'd4, 10'd7, 32'h0100_0000, 0);
        send_request(24'd5, 10'd7, 32'h0, 0);
        send_request(24'd6, 10'd7, 32'h0, 2);
        i_valid <= 1'b0;
        drain();
        // burn-in not a multiple of the interval, unkept iterations
        write_reg(REG_KEEP_EVERY, 24'd4);
        write_reg(REG_BURN_IN, 24'd10);
        send_request(24'd8, 10'd9, 32'h0200_0000, 0);
        send_request(24'd11, 10'd9, 32'h0200_0000, 0);
        send_request(24'd12, 10'd9, 32'hfe00_0000, 0);
        send_request(24'd16, 10'd9, 32'h0300_0000, 0);
        send_request(24'd16, 10'd512, 32'h0, 0);
        i_valid <= 1'b0;
        drain();
        write_reg(REG_KEEP_EVERY, 24'hffff);
        write_reg(REG_BURN_IN, 24'hffffff);
        send_request(24'hffffff, 10'd3, 32'h1234_5678, 0);
        send_request(24'hfeff01, 10'd3, 32'h1234_5678, 0);
        send_request(24'h0, 10'd3, 32'h1234_5678, 0);
        i_valid <= 1'b0;
        drain();

        random_phase(220, 16'd1, 24'd0, 1'b0);
        random_phase(200, 16'd3, 24'd7, 1'b1);
        random_phase(180, 16'd0, 24'd100, 1'b1);
        random_phase(150, 16'hffff, 24'h0, 1'b0);
        random_phase(180, 16'($urandom_range(1, 20)), 24'($urandom_range(0, 500)), 1'b1);

        drain();
        $display("covered %0d requests, %0d results, %0d kept, across several thinning settings",
                 sent, results, kept_count);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
